// ===== design/rtlt_pkg.sv =====
// Shared constants and types for the refcounted tile lock table.
package rtlt_pkg;

    localparam int ENTRIES    = 64;
    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = $clog2(ENTRIES);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [IDX_BITS-1:0]   IDX_LAST  = IDX_BITS'(ENTRIES - 1);

    typedef enum logic [1:0] {
        CMD_LOCK   = 2'd0,
        CMD_UNLOCK = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_FORCE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_COMPARE,
        S_FINISH,
        S_OUT_MORE,
        S_OUT_LAST
    } state_t;

endpackage

// ===== design/refcounted_tile_lock_table_core.sv =====
// Reference-counted tile lock table with a sequential slot scanner.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready  | command, producer_handle, local_address
//  out     | output    | out_valid / out_ready| flag, status, tile_valid, out_producer,
//          |           |                      | out_local_address, last
//
// Each slot is checked by a memory read (S_READ) followed by a compare (S_COMPARE).
// Lock, unlock and query scan from slot 0 until a slot matches or all slots are
// checked, then make one output transaction. Force unlock scans all slots, with one
// output transaction per freed tile (a single one if none is freed). A registered
// slot read precedes each compare. Reset clears the per-slot valid flops at once;
// no input transaction is taken until the previous item's last result is accepted.
module refcounted_tile_lock_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] producer_handle,
    input  logic [31:0] local_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        flag,
    output logic [1:0]  status,
    output logic        tile_valid,
    output logic [31:0] out_producer,
    output logic [31:0] out_local_address,
    output logic        last
);

    localparam int IW = rtlt_pkg::IDX_BITS;
    localparam int CW = rtlt_pkg::COUNT_BITS;

    logic [31:0]   mem_prod  [rtlt_pkg::ENTRIES];
    logic [31:0]   mem_local [rtlt_pkg::ENTRIES];
    logic [CW-1:0] mem_count [rtlt_pkg::ENTRIES];

    logic [rtlt_pkg::ENTRIES-1:0] vld_reg;

    rtlt_pkg::state_t state_reg, state_next;
    rtlt_pkg::cmd_t   cmd_reg, cmd_next;
    logic [31:0]   prod_reg, prod_next;
    logic [31:0]   loc_reg, loc_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [31:0]   pend_local_reg, pend_local_next;

    logic [31:0]   rd_prod_reg;
    logic [31:0]   rd_local_reg;
    logic [CW-1:0] rd_count_reg;

    logic          flag_reg, flag_next;
    logic [1:0]    status_reg, status_next;
    logic          tile_valid_reg, tile_valid_next;
    logic [31:0]   oprod_reg, oprod_next;
    logic [31:0]   oloc_reg, oloc_next;
    logic          last_reg, last_next;

    logic          we_key, we_count;
    logic [IW-1:0] waddr;
    logic [CW-1:0] wcount;
    logic          vld_set, vld_clr;

    logic          cur_vld, hit, at_end, free_avail;
    logic [IW-1:0] free_take;

    assign in_ready  = (state_reg == rtlt_pkg::S_IDLE);
    assign out_valid = (state_reg == rtlt_pkg::S_OUT_MORE) ||
                       (state_reg == rtlt_pkg::S_OUT_LAST);

    assign flag              = flag_reg;
    assign status            = status_reg;
    assign tile_valid        = tile_valid_reg;
    assign out_producer      = oprod_reg;
    assign out_local_address = oloc_reg;
    assign last              = last_reg;

    assign cur_vld    = vld_reg[idx_reg];
    assign hit        = cur_vld && (rd_prod_reg == prod_reg) &&
                        ((cmd_reg == rtlt_pkg::CMD_FORCE) || (rd_local_reg == loc_reg));
    assign at_end     = (idx_reg == rtlt_pkg::IDX_LAST);
    assign free_avail = free_found_reg || !cur_vld;
    assign free_take  = free_found_reg ? free_idx_reg : idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        prod_next       = prod_reg;
        loc_next        = loc_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_local_next = pend_local_reg;
        flag_next       = flag_reg;
        status_next     = status_reg;
        tile_valid_next = tile_valid_reg;
        oprod_next      = oprod_reg;
        oloc_next       = oloc_reg;
        last_next       = last_reg;
        we_key          = 1'b0;
        we_count        = 1'b0;
        waddr           = idx_reg;
        wcount          = rd_count_reg;
        vld_set         = 1'b0;
        vld_clr         = 1'b0;

        case (state_reg)
            rtlt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = rtlt_pkg::cmd_t'(command);
                    prod_next       = producer_handle;
                    loc_next        = local_address;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = rtlt_pkg::S_READ;
                end
            end

            rtlt_pkg::S_READ:
            begin
                state_next = rtlt_pkg::S_COMPARE;
            end

            rtlt_pkg::S_COMPARE:
            begin
                // default single-result answer
                flag_next       = 1'b0;
                status_next     = rtlt_pkg::ST_OK;
                tile_valid_next = 1'b0;
                oprod_next      = '0;
                oloc_next       = '0;
                last_next       = 1'b1;
                state_next      = rtlt_pkg::S_READ;
                idx_next        = idx_reg + IW'(1);

                case (cmd_reg)
                    rtlt_pkg::CMD_LOCK:
                    begin
                        if (hit)
                        begin
                            if (rd_count_reg == rtlt_pkg::COUNT_MAX)
                            begin
                                status_next = rtlt_pkg::ST_SAT;
                            end
                            else
                            begin
                                we_count = 1'b1;
                                wcount   = rd_count_reg + CW'(1);
                            end
                            state_next = rtlt_pkg::S_OUT_LAST;
                        end
                        else if (at_end)
                        begin
                            if (free_avail)
                            begin
                                we_key    = 1'b1;
                                we_count  = 1'b1;
                                waddr     = free_take;
                                wcount    = rtlt_pkg::COUNT_ONE;
                                vld_set   = 1'b1;
                                flag_next = 1'b1;
                            end
                            else
                            begin
                                status_next = rtlt_pkg::ST_FULL;
                            end
                            state_next = rtlt_pkg::S_OUT_LAST;
                        end
                        else if (!free_found_reg && !cur_vld)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                    end

                    rtlt_pkg::CMD_UNLOCK:
                    begin
                        if (hit)
                        begin
                            if (rd_count_reg == rtlt_pkg::COUNT_ONE)
                            begin
                                vld_clr   = 1'b1;
                                flag_next = 1'b1;
                            end
                            else
                            begin
                                we_count = 1'b1;
                                wcount   = rd_count_reg - CW'(1);
                            end
                            state_next = rtlt_pkg::S_OUT_LAST;
                        end
                        else if (at_end)
                        begin
                            state_next = rtlt_pkg::S_OUT_LAST;
                        end
                    end

                    rtlt_pkg::CMD_QUERY:
                    begin
                        if (hit || at_end)
                        begin
                            flag_next  = hit;
                            state_next = rtlt_pkg::S_OUT_LAST;
                        end
                    end

                    default:
                    begin
                        // force unlock: hold one freed tile back so last can be set
                        idx_next = idx_reg;
                        if (hit)
                        begin
                            vld_clr         = 1'b1;
                            pend_valid_next = 1'b1;
                            pend_local_next = rd_local_reg;
                            if (pend_valid_reg)
                            begin
                                tile_valid_next = 1'b1;
                                oprod_next      = prod_reg;
                                oloc_next       = pend_local_reg;
                                last_next       = 1'b0;
                                state_next      = rtlt_pkg::S_OUT_MORE;
                            end
                            else if (at_end)
                            begin
                                state_next = rtlt_pkg::S_FINISH;
                            end
                            else
                            begin
                                idx_next = idx_reg + IW'(1);
                            end
                        end
                        else if (at_end)
                        begin
                            state_next = rtlt_pkg::S_FINISH;
                        end
                        else
                        begin
                            idx_next = idx_reg + IW'(1);
                        end
                    end
                endcase
            end

            rtlt_pkg::S_FINISH:
            begin
                flag_next       = 1'b0;
                status_next     = rtlt_pkg::ST_OK;
                tile_valid_next = pend_valid_reg;
                oprod_next      = pend_valid_reg ? prod_reg : '0;
                oloc_next       = pend_valid_reg ? pend_local_reg : '0;
                last_next       = 1'b1;
                state_next      = rtlt_pkg::S_OUT_LAST;
            end

            rtlt_pkg::S_OUT_MORE:
            begin
                if (out_ready)
                begin
                    if (at_end)
                    begin
                        state_next = rtlt_pkg::S_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = rtlt_pkg::S_READ;
                    end
                end
            end

            rtlt_pkg::S_OUT_LAST:
            begin
                if (out_ready)
                begin
                    state_next = rtlt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rtlt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtlt_pkg::S_IDLE;
            vld_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (vld_set)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (vld_clr)
            begin
                vld_reg[idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        prod_reg       <= prod_next;
        loc_reg        <= loc_next;
        idx_reg        <= idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        pend_valid_reg <= pend_valid_next;
        pend_local_reg <= pend_local_next;
        flag_reg       <= flag_next;
        status_reg     <= status_next;
        tile_valid_reg <= tile_valid_next;
        oprod_reg      <= oprod_next;
        oloc_reg       <= oloc_next;
        last_reg       <= last_next;
    end

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we_key)
        begin
            mem_prod[waddr]  <= prod_reg;
            mem_local[waddr] <= loc_reg;
        end
        if (we_count)
        begin
            mem_count[waddr] <= wcount;
        end
        rd_prod_reg  <= mem_prod[idx_reg];
        rd_local_reg <= mem_local[idx_reg];
        rd_count_reg <= mem_count[idx_reg];
    end

endmodule
